FILE: hdl/pcb_pkg.sv
`default_nettype none

package pcb_pkg;

    // Line length bound and derived widths
    localparam int LINE_LIMIT = 4096;
    localparam int POS_W      = $clog2(LINE_LIMIT + 1);
    localparam int OFF_W      = 12;
    localparam int CMP_W      = ((POS_W > OFF_W) ? POS_W : OFF_W) + 1;
    localparam int OCT_W      = 10;
    localparam int IP_W       = 32;

    // Slave-side data width: line_byte, arg_start, source_ip, padded to bytes
    localparam int S_DATA_W   = ((8 + OFF_W + IP_W + 7) / 8) * 8;
    localparam int M_DATA_W   = 8;

    // Argument length past the offset must exceed this for a bounce
    localparam int MIN_ARG_LEN = 7;

    // Parse phase codes
    localparam logic [1:0] PH_SEEK    = 2'd0;
    localparam logic [1:0] PH_PARSE   = 2'd1;
    localparam logic [1:0] PH_DECIDED = 2'd2;
    localparam logic [1:0] PH_REJECT  = 2'd3;

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;

    // One input beat, unpacked
    typedef struct packed {
        logic [7:0]       line_byte;
        logic             last_byte;
        logic [OFF_W-1:0] arg_start;
        logic [IP_W-1:0]  source_ip;
        logic             port_command;
    } pcb_item_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_white(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

`default_nettype wire

FILE: hdl/pcb_parser.sv
`default_nettype none

module pcb_parser
    import pcb_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      item_valid,
    input  wire pcb_item_t item,
    output logic           bounce
);

    logic [POS_W-1:0] pos_reg,     pos_next;
    logic [1:0]       phase_reg,   phase_next;
    logic [OCT_W-1:0] octet_reg,   octet_next;
    logic [1:0]       digits_reg,  digits_next;
    logic [2:0]       octets_reg,  octets_next;
    logic             space_reg,   space_next;
    logic [IP_W-1:0]  addr_reg,    addr_next;
    logic             verdict_reg, verdict_next;

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] off_ext;
    logic             in_args;
    logic             c_digit;
    logic             c_white;
    logic             c_comma;
    logic [12:0]      octet_x10;
    logic [IP_W-1:0]  addr_shifted;
    logic             finish;

    assign pos_ext      = CMP_W'(pos_reg);
    assign off_ext      = CMP_W'(item.arg_start);
    assign in_args      = (pos_ext >= off_ext);
    assign c_digit      = is_digit(item.line_byte);
    assign c_white      = is_white(item.line_byte);
    assign c_comma      = (item.line_byte == CH_COMMA);
    // ASCII digits carry their value in the low nibble
    assign octet_x10    = {octet_reg, 3'b000} + {2'b00, octet_reg, 1'b0}
                        + {9'b0, item.line_byte[3:0]};
    assign addr_shifted = {addr_reg[IP_W-9:0], octet_reg[7:0]};

    // Advance the line parse by one beat
    always_comb begin
        pos_next     = pos_reg;
        phase_next   = phase_reg;
        octet_next   = octet_reg;
        digits_next  = digits_reg;
        octets_next  = octets_reg;
        space_next   = space_reg;
        addr_next    = addr_reg;
        verdict_next = verdict_reg;
        finish       = 1'b0;
        bounce       = 1'b0;

        if (item_valid) begin
            if (in_args) begin
                unique case (phase_reg)
                    PH_SEEK, PH_PARSE: begin
                        if (phase_reg == PH_SEEK && !c_digit) begin
                            phase_next = PH_SEEK;
                        end else if (space_reg) begin
                            // only white space or the comma may follow a space
                            if (c_comma) begin
                                finish = 1'b1;
                            end else if (!c_white) begin
                                phase_next = PH_REJECT;
                            end
                        end else if (c_digit) begin
                            phase_next = PH_PARSE;
                            if (digits_reg == 2'd3) begin
                                phase_next = PH_REJECT;
                            end else begin
                                octet_next  = octet_x10[OCT_W-1:0];
                                digits_next = digits_reg + 2'd1;
                            end
                        end else if (octet_reg[OCT_W-1:8] != '0) begin
                            // octet above 255 at its terminator
                            phase_next = PH_REJECT;
                        end else if (c_white) begin
                            space_next = 1'b1;
                        end else if (c_comma) begin
                            finish = 1'b1;
                        end else begin
                            phase_next = PH_REJECT;
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase

                // Shift the completed octet in and decide after the fourth
                if (finish) begin
                    addr_next   = addr_shifted;
                    octets_next = octets_reg + 3'd1;
                    octet_next  = '0;
                    digits_next = '0;
                    space_next  = 1'b0;
                    if (octets_reg == 3'd3) begin
                        verdict_next = (addr_shifted != item.source_ip);
                        phase_next   = PH_DECIDED;
                    end
                end
            end

            // Saturate the position at the line limit
            if (pos_ext < CMP_W'(LINE_LIMIT)) begin
                pos_next = pos_reg + 1'b1;
            end

            // Report and clear at the end of the line
            if (item.last_byte) begin
                bounce = (phase_next == PH_DECIDED) && verdict_next
                       && item.port_command
                       && ((pos_ext + 1'b1) > (off_ext + CMP_W'(MIN_ARG_LEN)));
                pos_next     = '0;
                phase_next   = PH_SEEK;
                octet_next   = '0;
                digits_next  = '0;
                octets_next  = '0;
                space_next   = 1'b0;
                addr_next    = '0;
                verdict_next = 1'b0;
            end
        end
    end

    // Hold the line state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            phase_reg   <= PH_SEEK;
            octet_reg   <= '0;
            digits_reg  <= '0;
            octets_reg  <= '0;
            space_reg   <= 1'b0;
            addr_reg    <= '0;
            verdict_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            octet_reg   <= octet_next;
            digits_reg  <= digits_next;
            octets_reg  <= octets_next;
            space_reg   <= space_next;
            addr_reg    <= addr_next;
            verdict_reg <= verdict_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/port_command_bounce_check.sv
// Channel  Dir  Handshake        tdata (low bit up)                          tlast      tuser
// s_       in   s_tvalid/tready  line_byte[7:0] arg_start[19:8] src[51:20]   last_byte  port_command
// m_       out  m_tvalid/tready  bounce[0]                                   -          -
//
// One byte beat per cycle unless a line end waits on a stalled output; an accepted
// beat is registered in the input register and parsed as it leaves it, which also
// loads its result (on last_byte only) into the output register that drives m_tvalid.
// Throughput is one beat per cycle while no line end waits on a stalled output.
// Reset (aresetn low, synchronous) clears the line state and both stages.
// A stalled output holds only beats that end a line; other beats keep flowing.
`default_nettype none

module port_command_bounce_check
    import pcb_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // line_byte, arg_start, source_ip, zero pad
    input  wire logic                s_tlast,
    input  wire logic                s_tuser,   // port_command
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata    // bounce, zero pad
);

    pcb_item_t in_item_reg, in_item_next;
    logic      in_valid_reg;
    logic      m_valid_reg;
    logic      m_bounce_reg;
    logic      advance;
    logic      result;

    assign in_item_next = '{
        line_byte:    s_tdata[7:0],
        last_byte:    s_tlast,
        arg_start:    s_tdata[8+OFF_W-1:8],
        source_ip:    s_tdata[8+OFF_W+IP_W-1:8+OFF_W],
        port_command: s_tuser
    };

    // A beat leaves the input register unless its result has nowhere to go
    assign advance  = in_valid_reg && (!in_item_reg.last_byte || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    pcb_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (advance),
        .item       (in_item_reg),
        .bounce     (result)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= in_item_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_item_reg.last_byte) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_item_reg.last_byte) begin
            m_bounce_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W-1){1'b0}}, m_bounce_reg};

`ifndef ASSERT_OFF
    // An empty input register always takes a beat
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input register empty but not ready");

    // A result appears only from a beat that ends a line
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(advance && in_item_reg.last_byte))
        else $error("result without line end");

    // A held beat stays put in the input register
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("held beat lost or changed");

    // An accepted beat lands in the input register
    a_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted beat not captured");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_port_command_bounce_check.sv
`timescale 1ns / 1ps

module tb_port_command_bounce_check;
    import pcb_pkg::*;

    localparam int OCTET_MAX    = 255;
    localparam int MAX_DIGITS   = 3;
    localparam int NUM_OCTETS   = 4;
    localparam int GAP_MAX      = 18;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RAND_BEATS   = 1620;
    localparam int MAX_REPORTS  = 40;

    // How a table row's result is judged: by the predictor or by a typed value
    typedef enum logic [1:0] {WANT_MODEL, WANT_CLEAR, WANT_BOUNCE} want_t;

    typedef struct {
        pcb_item_t item;
        want_t     want;
    } dir_row_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // line_byte, arg_start, source_ip, zero pad
    logic                s_tlast  = 1'b0; // last_byte
    logic                s_tuser  = 1'b0; // port_command
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // bounce, zero pad

    // Line tracker state
    int unsigned line_pos;
    logic [1:0]  scan_phase;
    int unsigned octet_acc;
    int unsigned digits_in_octet;
    int unsigned octets_done;
    bit          blank_after_octet;
    logic [31:0] addr_built;
    bit          addr_differs;

    bit          bounce_expected[$];
    dir_row_t    dir_rows[$];
    logic [7:0]  line_text[$];

    bit send_rush = 1'b0;
    bit take_rush = 1'b0;
    int mismatches    = 0;
    int beats_sent    = 0;
    int lines_sent    = 0;
    int results_seen  = 0;
    int bounces_seen  = 0;
    int idle_cycles   = 0;

    port_command_bounce_check u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit is_decimal_char(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic bit is_blank_char(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic [7:0] non_digit();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (is_decimal_char(c));
        return c;
    endfunction

    function automatic void clear_line_state();
        line_pos          = 0;
        scan_phase        = PH_SEEK;
        octet_acc         = 0;
        digits_in_octet   = 0;
        octets_done       = 0;
        blank_after_octet = 1'b0;
        addr_built        = '0;
        addr_differs      = 1'b0;
    endfunction

    // Shift the finished octet into the address; decide after the fourth
    function automatic void close_octet(logic [31:0] src);
        addr_built        = {addr_built[23:0], octet_acc[7:0]};
        octets_done       = octets_done + 1;
        octet_acc         = 0;
        digits_in_octet   = 0;
        blank_after_octet = 1'b0;
        if (octets_done == NUM_OCTETS) begin
            addr_differs = (addr_built != src);
            scan_phase   = PH_DECIDED;
        end
    endfunction

    function automatic void scan_char(logic [7:0] c, logic [31:0] src);
        if (scan_phase == PH_SEEK) begin
            if (!is_decimal_char(c))
                return;
            scan_phase = PH_PARSE;
        end
        if (scan_phase != PH_PARSE)
            return;
        // only blanks or the comma may follow a blank
        if (blank_after_octet) begin
            if (is_blank_char(c))
                return;
            if (c == CH_COMMA)
                close_octet(src);
            else
                scan_phase = PH_REJECT;
            return;
        end
        if (is_decimal_char(c)) begin
            if (digits_in_octet >= MAX_DIGITS) begin
                scan_phase = PH_REJECT;
                return;
            end
            octet_acc       = octet_acc * 10 + (c - CH_ZERO);
            digits_in_octet = digits_in_octet + 1;
            return;
        end
        // terminator of an oversized octet
        if (octet_acc > OCTET_MAX) begin
            scan_phase = PH_REJECT;
            return;
        end
        if (is_blank_char(c))
            blank_after_octet = 1'b1;
        else if (c == CH_COMMA)
            close_octet(src);
        else
            scan_phase = PH_REJECT;
    endfunction

    // Advance the tracker by one beat; the verdict only matters on last_byte
    function automatic bit predict_bounce(pcb_item_t it);
        int unsigned idx;
        bit          bounce;
        idx = line_pos;
        if (idx >= it.arg_start)
            scan_char(it.line_byte, it.source_ip);
        if (idx < LINE_LIMIT)
            line_pos = idx + 1;
        bounce = (scan_phase == PH_DECIDED) && addr_differs && it.port_command
                 && (idx + 1 > it.arg_start + MIN_ARG_LEN);
        if (it.last_byte)
            clear_line_state();
        return bounce;
    endfunction

    task automatic flag_mismatch(string what);
        if (mismatches < MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    // Drive one beat after a random hold-off and wait for the handshake
    task automatic send_beat(pcb_item_t it, want_t want);
        int gap;
        bit predicted;
        gap = send_rush ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({it.source_ip, it.arg_start, it.line_byte});
        s_tlast  <= it.last_byte;
        s_tuser  <= it.port_command;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = predict_bounce(it);
        beats_sent++;
        if (it.last_byte) begin
            lines_sent++;
            case (want)
                WANT_CLEAR:  bounce_expected.push_back(1'b0);
                WANT_BOUNCE: bounce_expected.push_back(1'b1);
                default:     bounce_expected.push_back(predicted);
            endcase
        end
    endtask

    task automatic add_line(string text, logic [11:0] off, logic [31:0] src, logic port,
                            want_t want);
        dir_row_t r;
        for (int i = 0; i < text.len(); i++) begin
            r.item.line_byte    = text[i];
            r.item.last_byte    = (i == text.len() - 1);
            r.item.arg_start    = off;
            r.item.source_ip    = src;
            r.item.port_command = port;
            r.want              = r.item.last_byte ? want : WANT_MODEL;
            dir_rows.push_back(r);
        end
    endtask

    // Mostly well-formed PORT arguments with random content, some of them broken
    task automatic make_port_line(output logic [11:0] off, output logic [31:0] src);
        int unsigned r;
        int unsigned lead;
        int unsigned val;
        int unsigned cut;
        int          ndig;
        logic [31:0] addr;
        addr = '0;
        line_text.delete();
        r = $urandom_range(0, 19);
        if (r < 14)
            off = 12'($urandom_range(0, 6));
        else if (r < 19)
            off = 12'($urandom_range(7, 40));
        else
            off = 12'($urandom_range(0, 4095));
        // arbitrary bytes ahead of the arguments
        lead = (off <= 40) ? off : $urandom_range(0, 12);
        repeat (lead) line_text.push_back(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 3)) line_text.push_back(non_digit());
        for (int k = 0; k < NUM_OCTETS; k++) begin
            r = $urandom_range(0, 39);
            if (r == 0 && k > 0) begin
                ndig = 0;
                val  = 0;
            end else if (r == 1) begin
                ndig = 4;
                val  = $urandom_range(0, 9999);
            end else if (r == 2) begin
                ndig = MAX_DIGITS;
                val  = $urandom_range(OCTET_MAX + 1, 999);
            end else begin
                ndig = $urandom_range(1, MAX_DIGITS);
                val  = $urandom_range(0, (ndig == 1) ? 9 : (ndig == 2) ? 99 : OCTET_MAX);
            end
            for (int j = ndig - 1; j >= 0; j--)
                line_text.push_back(8'(CH_ZERO + (val / (10 ** j)) % 10));
            addr = {addr[23:0], val[7:0]};
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 2)) begin
                    r = $urandom_range(0, 5);
                    line_text.push_back((r == 5) ? CH_SPACE : 8'(CH_TAB + r));
                end
            end
            line_text.push_back(CH_COMMA);
        end
        // tail bytes after the decision
        repeat ($urandom_range(0, 3)) line_text.push_back(8'($urandom_range(0, 255)));
        // corrupt or cut some lines
        if ($urandom_range(0, 5) == 0)
            line_text[$urandom_range(0, line_text.size() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 11) == 0) begin
            cut = $urandom_range(1, line_text.size());
            while (line_text.size() > cut) line_text.delete(line_text.size() - 1);
        end
        src = $urandom_range(0, 1) ? addr : $urandom;
    endtask

    task automatic send_line(logic [11:0] off, logic [31:0] src, logic port, bit mixed);
        pcb_item_t it;
        for (int i = 0; i < line_text.size(); i++) begin
            it.line_byte    = line_text[i];
            it.last_byte    = (i == line_text.size() - 1);
            it.arg_start    = mixed ? 12'($urandom_range(0, 8)) : off;
            it.source_ip    = src;
            it.port_command = mixed ? 1'($urandom_range(0, 1)) : port;
            send_beat(it, WANT_MODEL);
        end
    endtask

    // Check each result against the oldest expectation
    always @(posedge aclk) begin : check_results
        bit want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (bounce_expected.size() == 0) begin
                flag_mismatch($sformatf("result with nothing pending, bounce=%0b", m_tdata[0]));
            end else begin
                want = bounce_expected.pop_front();
                if (m_tdata[0] !== want)
                    flag_mismatch($sformatf("bounce=%0b, predicted %0b", m_tdata[0], want));
                if (want)
                    bounces_seen++;
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: random stalls, sometimes held low until a result shows up
    initial begin : result_sink
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 7) == 0)
                take_rush = !take_rush;
            gap = take_rush ? 0 : $urandom_range(0, GAP_MAX);
            if (gap > 0) begin
                m_tready <= 1'b0;
                if ($urandom_range(0, 1)) begin
                    @(posedge aclk);
                    while (!m_tvalid) @(posedge aclk);
                end
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin : stimulus
        logic [11:0] off;
        logic [31:0] src;
        int          rand_beats;
        clear_line_state();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed lines: widest offset hides the only byte
        add_line("~", 12'd4095, 32'hFFFF_FFFF, 1'b1, WANT_CLEAR);
        // matching address, blank before a comma, empty octets
        add_line("255\t,,,9,", 12'd0, 32'hFF00_0009, 1'b1, WANT_CLEAR);
        // differing address gives a bounce
        add_line("1,2,3,4,", 12'd0, 32'hFFFF_FFFF, 1'b1, WANT_BOUNCE);
        // bad character, fourth digit, octet too large
        add_line("1a", 12'd0, 32'h0000_0000, 1'b1, WANT_CLEAR);
        add_line("1234", 12'd0, 32'h0000_0000, 1'b1, WANT_CLEAR);
        add_line("256,", 12'd0, 32'h0000_0000, 1'b1, WANT_CLEAR);
        foreach (dir_rows[i])
            send_beat(dir_rows[i].item, dir_rows[i].want);

        // Random lines, a few with per-beat offset and command flag
        rand_beats = 0;
        while (rand_beats < RAND_BEATS) begin
            if ($urandom_range(0, 4) == 0)
                send_rush = !send_rush;
            make_port_line(off, src);
            send_line(off, src, $urandom_range(0, 6) != 0, $urandom_range(0, 19) == 0);
            rand_beats += line_text.size();
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        while (bounce_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d lines in %0d beats (%0d table rows, the rest random).",
                 lines_sent, beats_sent, dir_rows.size());
        $display("Checked %0d results, %0d of them bounces; %0d mismatches.",
                 results_seen, bounces_seen, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
hdl/pcb_pkg.sv
hdl/pcb_parser.sv
hdl/port_command_bounce_check.sv
sim/tb_port_command_bounce_check.sv
